// ===== src/sliding_window_reorder_buffer_core_macros.svh =====
// Assertion macros shared by the reorder buffer modules.
`ifndef SLIDING_WINDOW_REORDER_BUFFER_CORE_MACROS_SVH
`define SLIDING_WINDOW_REORDER_BUFFER_CORE_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define SWRB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swrb: same-cycle check failed");

// Next-cycle implication, checked on clk, off while rst is high.
`define SWRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swrb: next-cycle check failed");

`endif

// ===== src/swrb_pkg.sv =====
// Types and constants of the sliding window reorder buffer.
`default_nettype none
package swrb_pkg;

  localparam int OFFSET_W   = 32;
  localparam int PKT_NUM_W  = 22;
  localparam int LEN_W      = 11;
  localparam int BYTE_IDX_W = 10;
  localparam int DATA_W     = 8;
  localparam int STATUS_W   = 3;

  // Fixed packet size: packet number is the offset with the low bits dropped.
  localparam int PACKET_BYTES = 1024;
  localparam int OFFSET_SHIFT = $clog2(PACKET_BYTES);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_BADLEN    = 3'd4,
    ST_DELIVERED = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic commit;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/swrb_if.sv =====
// Request and response channel interfaces of the reorder buffer.
`default_nettype none
interface swrb_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] byte_offset;
  logic [10:0] payload_length;
  logic [9:0]  byte_index;
  logic [7:0]  data_byte;
  logic        last_byte;

  modport source (
    output valid, req_type, byte_offset, payload_length, byte_index, data_byte,
           last_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_offset, payload_length, byte_index, data_byte,
           last_byte,
    output ready
  );
endinterface

interface swrb_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  read_byte;
  logic        end_of_packet;
  logic [21:0] head_packet_number;

  modport source (
    output valid, status, read_byte, end_of_packet, head_packet_number,
    input  ready
  );
  modport sink (
    input  valid, status, read_byte, end_of_packet, head_packet_number,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/swrb_ctrl.sv =====
// Controller: sequences one word through capture, decode and execute.
`default_nettype none
`include "sliding_window_reorder_buffer_core_macros.svh"
module swrb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output swrb_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.decode  = (state == S_DECODE);
    cmd.commit  = (state == S_EXEC) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state    <= S_DECODE;
            in_ready <= 1'b0;
          end
        end
        S_DECODE: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.commit) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  `SWRB_ASSERT_NOW(a_ready_only_idle, 1'b1, in_ready == (state == S_IDLE))
  `SWRB_ASSERT_NEXT(a_commit_fills_out, cmd.commit, out_valid)
  `SWRB_ASSERT_NEXT(a_exec_holds, (state == S_EXEC) && !cmd.commit, state == S_EXEC)

endmodule
`default_nettype wire

// ===== src/swrb_datapath.sv =====
// Datapath: window state, slot flags, length and packet stores, result register.
`default_nettype none
`include "sliding_window_reorder_buffer_core_macros.svh"
module swrb_datapath #(
  parameter int WINDOW_SLOTS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire swrb_pkg::cmd_t                      cmd,
  input  wire logic                                req_type,
  input  wire logic [swrb_pkg::OFFSET_W-1:0]       byte_offset,
  input  wire logic [swrb_pkg::LEN_W-1:0]          payload_length,
  input  wire logic [swrb_pkg::BYTE_IDX_W-1:0]     byte_index,
  input  wire logic [swrb_pkg::DATA_W-1:0]         data_byte,
  input  wire logic                                last_byte,
  output logic [swrb_pkg::STATUS_W-1:0]            status,
  output logic [swrb_pkg::DATA_W-1:0]              read_byte,
  output logic                                     end_of_packet,
  output logic [swrb_pkg::PKT_NUM_W-1:0]           head_packet_number
);

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int ADDR_W = SLOT_W + swrb_pkg::BYTE_IDX_W;
  localparam int DEPTH  = WINDOW_SLOTS * swrb_pkg::PACKET_BYTES;
  localparam int PN_W   = swrb_pkg::PKT_NUM_W;
  localparam int LEN_W  = swrb_pkg::LEN_W;
  localparam int IDX_W  = swrb_pkg::BYTE_IDX_W;

  // captured word
  logic                          req_q;
  logic [PN_W-1:0]               pkt_q;
  logic [LEN_W-1:0]              plen_q;
  logic [IDX_W-1:0]              bidx_q;
  logic [swrb_pkg::DATA_W-1:0]   data_q;
  logic                          last_q;

  // decoded word
  logic                          outside_q;
  logic                          badlen_q;
  logic [SLOT_W-1:0]             slot_q;

  // window state
  logic [SLOT_W-1:0]             head;
  logic [PN_W-1:0]               base;
  logic [IDX_W-1:0]              rpos;
  logic [WINDOW_SLOTS-1:0]       complete;

  logic [swrb_pkg::DATA_W-1:0]   store [0:DEPTH-1];
  logic [LEN_W-1:0]              len_mem [0:WINDOW_SLOTS-1];
  logic [swrb_pkg::DATA_W-1:0]   store_rdata;
  logic [LEN_W-1:0]              len_rdata;

  // decode logic
  logic [PN_W-1:0]               pkt_dist;
  logic [SLOT_W:0]               slot_sum;
  logic [SLOT_W:0]               slot_mod;
  logic                          outside;
  logic                          badlen;

  // execute logic
  swrb_pkg::status_t             status_next;
  logic [swrb_pkg::DATA_W-1:0]   rbyte_next;
  logic                          eop_next;
  logic                          wr_store;
  logic                          wr_done;
  logic                          rd_adv;
  logic [LEN_W-1:0]              rpos_inc;
  logic [SLOT_W-1:0]             head_next;
  logic [PN_W-1:0]               base_next;

  always_comb begin
    pkt_dist = pkt_q - base;
    outside  = pkt_dist >= PN_W'(WINDOW_SLOTS);
    slot_sum = {1'b0, head} + {1'b0, pkt_dist[SLOT_W-1:0]};
    if (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS)) begin
      slot_mod = slot_sum - (SLOT_W+1)'(WINDOW_SLOTS);
    end else begin
      slot_mod = slot_sum;
    end
    badlen = (plen_q == '0) || (plen_q > LEN_W'(swrb_pkg::PACKET_BYTES)) ||
             ({1'b0, bidx_q} >= plen_q);
  end

  always_comb begin
    status_next = swrb_pkg::ST_EMPTY;
    rbyte_next  = '0;
    eop_next    = 1'b0;
    wr_store    = 1'b0;
    wr_done     = 1'b0;
    rd_adv      = 1'b0;
    rpos_inc    = {1'b0, rpos} + LEN_W'(1);
    if (head == SLOT_W'(WINDOW_SLOTS - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + SLOT_W'(1);
    end
    if (req_q == swrb_pkg::REQ_READ) begin
      if (complete[head]) begin
        status_next = swrb_pkg::ST_DELIVERED;
        rbyte_next  = store_rdata;
        eop_next    = rpos_inc >= len_rdata;
        rd_adv      = 1'b1;
      end
    end else begin
      priority if (outside_q) begin
        status_next = swrb_pkg::ST_OUTSIDE;
      end else if (complete[slot_q]) begin
        status_next = swrb_pkg::ST_DUPLICATE;
      end else if (badlen_q) begin
        status_next = swrb_pkg::ST_BADLEN;
      end else begin
        wr_store = 1'b1;
        wr_done  = last_q;
        status_next = last_q ? swrb_pkg::ST_COMPLETE : swrb_pkg::ST_STORED;
      end
    end
    base_next = (rd_adv && eop_next) ? base + PN_W'(1) : base;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_type;
      pkt_q  <= byte_offset[swrb_pkg::OFFSET_W-1:swrb_pkg::OFFSET_SHIFT];
      plen_q <= payload_length;
      bidx_q <= byte_index;
      data_q <= data_byte;
      last_q <= last_byte;
    end
    if (cmd.decode) begin
      outside_q <= outside;
      badlen_q  <= badlen;
      slot_q    <= slot_mod[SLOT_W-1:0];
    end
    if (cmd.commit) begin
      status             <= status_next;
      read_byte          <= rbyte_next;
      end_of_packet      <= eop_next;
      head_packet_number <= base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      base     <= '0;
      rpos     <= '0;
      complete <= '0;
    end else if (cmd.commit) begin
      if (wr_done) begin
        complete[slot_q] <= 1'b1;
      end
      if (rd_adv) begin
        if (eop_next) begin
          complete[head] <= 1'b0;
          head           <= head_next;
          base           <= base_next;
          rpos           <= '0;
        end else begin
          rpos <= rpos_inc[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_store) begin
      store[ADDR_W'({slot_q, bidx_q})] <= data_q;
    end
    store_rdata <= store[ADDR_W'({head, rpos})];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_done) begin
      len_mem[slot_q] <= plen_q;
    end
    len_rdata <= len_mem[head];
  end

  `SWRB_ASSERT_NOW(a_rpos_idle_head, !complete[head], rpos == '0)
  `SWRB_ASSERT_NEXT(a_base_advance, cmd.commit && rd_adv && eop_next, base == $past(base) + PN_W'(1))
  `SWRB_ASSERT_NEXT(a_slot_marked, cmd.commit && wr_done, complete[$past(slot_q)])

endmodule
`default_nettype wire

// ===== src/sliding_window_reorder_buffer_core.sv =====
// Top level of the sliding window reorder buffer.
// Receive side of a selective-repeat window of WINDOW_SLOTS packets of 1024
// bytes each. A write word stores one payload byte in its packet's slot, or
// reports it outside the window, already received or of bad length; the last
// byte marks the slot complete. A read word returns the next in-order byte of
// the head packet, or reports empty if it is not complete, and frees the slot
// after its final byte, which advances the window. Each word gives one
// response word. A word passes through three steps from accept until the next
// word can be accepted: capture, decode (window distance and slot, packet
// store read issued), then execute. The response sits in an output register,
// so a pending response does not block the next accept, only the next
// execute. The packet store has no reset; reading a byte of a complete packet
// that was never written gives undefined data.
`default_nettype none
module sliding_window_reorder_buffer_core #(
  parameter int WINDOW_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  swrb_req_if.sink         req_ch,
  swrb_rsp_if.source       rsp_ch
);

  swrb_pkg::cmd_t cmd;

  swrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_ch.valid),
    .in_ready  (req_ch.ready),
    .out_valid (rsp_ch.valid),
    .out_ready (rsp_ch.ready),
    .cmd       (cmd)
  );

  swrb_datapath #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .req_type           (req_ch.req_type),
    .byte_offset        (req_ch.byte_offset),
    .payload_length     (req_ch.payload_length),
    .byte_index         (req_ch.byte_index),
    .data_byte          (req_ch.data_byte),
    .last_byte          (req_ch.last_byte),
    .status             (rsp_ch.status),
    .read_byte          (rsp_ch.read_byte),
    .end_of_packet      (rsp_ch.end_of_packet),
    .head_packet_number (rsp_ch.head_packet_number)
  );

endmodule
`default_nettype wire
